### rtl/icaf_pkg.sv
package icaf_pkg;

   localparam int TABLE_LEN  = 24;
   localparam int IDX_W      = 5;
   localparam int TABLE_FRAC = 24;
   localparam int Z_W        = 34;
   localparam int MUL_A_W    = 18;
   localparam int MUL_B_W    = 33;
   localparam int PROD_W     = MUL_A_W + MUL_B_W;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 17;
   localparam int REQ_W      = 112;
   localparam int RSP_W      = 112;

   typedef logic signed [Z_W-1:0] z_type;

   localparam z_type QUARTER_TURN = 34'sd1509949440;

   // atan(2^-i) in degrees, 24 fraction bits, rounded
   localparam z_type ATAN_TABLE [TABLE_LEN] = '{
      34'sd754974720, 34'sd445687602, 34'sd235489088, 34'sd119537938,
      34'sd60000934,  34'sd30029717,  34'sd15018523,  34'sd7509720,
      34'sd3754917,   34'sd1877466,   34'sd938734,    34'sd469367,
      34'sd234684,    34'sd117342,    34'sd58671,     34'sd29335,
      34'sd14668,     34'sd7334,      34'sd3667,      34'sd1833,
      34'sd917,       34'sd458,       34'sd229,       34'sd115
   };

   localparam logic [CSR_ADDR_W-1:0] REG_GYRO_WEIGHT    = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] REG_GYRO_STEP_GAIN = 1'b1;

   localparam logic [16:0]         WEIGHT_ONE   = 17'd65536;
   localparam logic [16:0]         WEIGHT_RESET = 17'd62415;
   localparam logic [15:0]         GAIN_RESET   = 16'd20;
   localparam logic signed [17:0]  TEMP_SCALE   = 18'sd50251;
   localparam logic signed [15:0]  TEMP_OFFSET  = 16'sd5376;
   localparam logic signed [35:0]  SAT_MAX      = 36'sd2147483647;
   localparam logic signed [35:0]  SAT_MIN      = -36'sd2147483648;

   typedef enum logic [3:0] {
      S_IDLE,
      S_GYRO_Y,
      S_GYRO_P,
      S_GYRO_R,
      S_TEMP,
      S_TEMP_FIN,
      S_WAIT_P,
      S_WAIT_R,
      S_BLEND_P,
      S_BLEND_R,
      S_BLEND_FIN,
      S_OUT
   } state_type;

   typedef struct packed {
      logic               start;
      logic signed [15:0] y;
      logic signed [15:0] x;
   } cordic_req_type;

   function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
      logic signed [31:0] r;
      if (v > SAT_MAX) begin
         r = 32'sh7FFFFFFF;
      end else if (v < SAT_MIN) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

### rtl/icaf_mul.sv
module icaf_mul
   import icaf_pkg::*;
(
   input  logic                      clock,
   input  logic signed [MUL_A_W-1:0] mul_a,
   input  logic signed [MUL_B_W-1:0] mul_b,
   output logic signed [PROD_W-1:0]  prod
);

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   always_comb begin
      prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

### rtl/icaf_cordic.sv
module icaf_cordic
   import icaf_pkg::*;
#(
   parameter int CORDIC_STEPS    = 16,
   parameter int ANGLE_FRAC_BITS = 16
)
(
   input  logic               clock,
   input  logic               reset,
   input  cordic_req_type     cordic_req,
   output logic               done,
   output logic signed [31:0] angle
);

   localparam int CNT_W = $clog2(CORDIC_STEPS);
   localparam int SHIFT = TABLE_FRAC - ANGLE_FRAC_BITS;
   localparam logic [CNT_W-1:0] LAST = CNT_W'(CORDIC_STEPS - 1);
   localparam z_type ROUND = z_type'(2 ** (SHIFT - 1));

   logic             busy_ff, round_ff, done_ff, zero_ff;
   logic [CNT_W-1:0] cnt_ff;
   z_type            x_ff, y_ff, z_ff;
   logic signed [31:0] angle_ff;

   z_type xs, ys, x0, y0, z0;
   z_type dx, dy, atan_step, x_in, y_in, z_in, z_rnd;

   // pre-rotate into the right half plane
   always_comb begin
      xs = z_type'(cordic_req.x) <<< 14;
      ys = z_type'(cordic_req.y) <<< 14;
      if (xs < 0) begin
         if (ys >= 0) begin
            x0 = ys;
            y0 = -xs;
            z0 = QUARTER_TURN;
         end else begin
            x0 = -ys;
            y0 = xs;
            z0 = -QUARTER_TURN;
         end
      end else begin
         x0 = xs;
         y0 = ys;
         z0 = '0;
      end
   end

   always_comb begin
      dx        = y_ff >>> cnt_ff;
      dy        = x_ff >>> cnt_ff;
      atan_step = ATAN_TABLE[IDX_W'(cnt_ff)];
      if (y_ff > 0) begin
         x_in = x_ff + dx;
         y_in = y_ff - dy;
         z_in = z_ff + atan_step;
      end else begin
         x_in = x_ff - dx;
         y_in = y_ff + dy;
         z_in = z_ff - atan_step;
      end
      z_rnd = (z_ff + ROUND) >>> SHIFT;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         round_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (cordic_req.start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == LAST) begin
            busy_ff  <= 1'b0;
            round_ff <= 1'b1;
         end else if (round_ff) begin
            round_ff <= 1'b0;
            done_ff  <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cordic_req.start) begin
         x_ff    <= x0;
         y_ff    <= y0;
         z_ff    <= z0;
         cnt_ff  <= '0;
         zero_ff <= (cordic_req.x == 16'sd0) && (cordic_req.y == 16'sd0);
      end else if (busy_ff) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         z_ff   <= z_in;
         cnt_ff <= cnt_ff + 1'b1;
      end
      if (round_ff) begin
         angle_ff <= zero_ff ? 32'sd0 : z_rnd[31:0];
      end
   end

   assign done  = done_ff;
   assign angle = angle_ff;

endmodule

### rtl/imu_complementary_attitude_filter.sv
// Complementary attitude filter for a six-axis inertial sensor.
//
// req_ channel: one raw sample per request (accel x/y/z, gyro x/y/z, temperature).
// rsp_ channel: one result per request with fused pitch and roll, integrated yaw
// (signed, ANGLE_FRAC_BITS fraction bits, degrees) and temperature in 1/256 C.
// csr_ port: index 0 is the gyro blend weight (Q1.16, values above one act as one),
// index 1 the angle step per gyro LSB. Write them only while the block is idle.
//
// One CORDIC unit resolves both tilt angles in turn, one step per cycle, and a
// single registered multiplier serves the gyro, temperature and blend products.
// req_tready is high only while no sample is in work, so a new request is taken
// only once the previous result has been loaded into the result register.
// The result register decouples the two sides: a new sample may be taken while the
// previous result waits; if the receiver still stalls when the next result is
// ready, the block holds it and accepts nothing more.
// Reset clears the angles to zero, loads the register defaults and drops rsp_tvalid.
module imu_complementary_attitude_filter
   import icaf_pkg::*;
#(
   parameter int CORDIC_STEPS    = 16,
   parameter int ANGLE_FRAC_BITS = 16
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // accel_x_raw, accel_y_raw, accel_z_raw, gyro_x_raw, gyro_y_raw, gyro_z_raw, temp_raw
   input  logic [REQ_W-1:0]      req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // pitch_deg, roll_deg, yaw_deg, temp_c
   output logic [RSP_W-1:0]      rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   state_type state_ff, state_in;

   logic [16:0] gyro_weight_ff;
   logic [15:0] gyro_step_gain_ff;

   logic signed [15:0] accel_x_ff, accel_y_ff, accel_z_ff;
   logic signed [15:0] gyro_x_ff, gyro_y_ff, gyro_z_ff, temp_raw_ff;

   logic signed [31:0] yaw_angle_ff, pitch_angle_ff, roll_angle_ff;
   logic signed [31:0] pitch_g_ff, roll_g_ff, pitch_a_ff, roll_a_ff;
   logic signed [15:0] temp_c_ff;

   logic             rsp_tvalid_ff;
   logic [RSP_W-1:0] rsp_tdata_ff;
   logic             rsp_load;

   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  prod;
   logic [16:0]               weight_eff;

   cordic_req_type     cordic_req;
   logic               cordic_done;
   logic signed [31:0] cordic_angle;

   logic signed [35:0]       prod_low;
   logic signed [PROD_W-1:0] prod_rnd;
   logic signed [35:0]       blend_step;
   logic signed [31:0]       pitch_blend, roll_blend, yaw_in, pitch_g_in, roll_g_in;
   logic signed [15:0]       temp_in;

   icaf_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   icaf_cordic #(
      .CORDIC_STEPS    (CORDIC_STEPS),
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
   ) u_cordic (
      .clock      (clock),
      .reset      (reset),
      .cordic_req (cordic_req),
      .done       (cordic_done),
      .angle      (cordic_angle)
   );

   assign weight_eff = (gyro_weight_ff > WEIGHT_ONE) ? WEIGHT_ONE : gyro_weight_ff;
   assign rsp_load   = (state_ff == S_OUT) && (!rsp_tvalid_ff || rsp_tready);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:      if (req_tvalid) state_in = S_GYRO_Y;
         S_GYRO_Y:    state_in = S_GYRO_P;
         S_GYRO_P:    state_in = S_GYRO_R;
         S_GYRO_R:    state_in = S_TEMP;
         S_TEMP:      state_in = S_TEMP_FIN;
         S_TEMP_FIN:  state_in = S_WAIT_P;
         S_WAIT_P:    if (cordic_done) state_in = S_WAIT_R;
         S_WAIT_R:    if (cordic_done) state_in = S_BLEND_P;
         S_BLEND_P:   state_in = S_BLEND_R;
         S_BLEND_R:   state_in = S_BLEND_FIN;
         S_BLEND_FIN: state_in = S_OUT;
         S_OUT:       if (rsp_load) state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   // sequencer outputs: request ready, multiplier operands and CORDIC launch
   always_comb begin
      req_tready   = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      cordic_req.start = 1'b0;
      cordic_req.y = accel_y_ff;
      cordic_req.x = accel_z_ff;
      case (state_ff)
         S_IDLE: req_tready = 1'b1;
         S_GYRO_Y: begin
            mul_a = $signed({2'b00, gyro_step_gain_ff});
            mul_b = MUL_B_W'(gyro_z_ff);
            cordic_req.start = 1'b1;
         end
         S_GYRO_P: begin
            mul_a = $signed({2'b00, gyro_step_gain_ff});
            mul_b = MUL_B_W'(gyro_x_ff);
         end
         S_GYRO_R: begin
            mul_a = $signed({2'b00, gyro_step_gain_ff});
            mul_b = MUL_B_W'(gyro_y_ff);
         end
         S_TEMP: begin
            mul_a = TEMP_SCALE;
            mul_b = MUL_B_W'(temp_raw_ff);
         end
         S_WAIT_P: begin
            cordic_req.start = cordic_done;
            cordic_req.y     = accel_x_ff;
         end
         S_BLEND_P: begin
            mul_a = $signed({1'b0, weight_eff});
            mul_b = MUL_B_W'(pitch_g_ff) - MUL_B_W'(pitch_a_ff);
         end
         S_BLEND_R: begin
            mul_a = $signed({1'b0, weight_eff});
            mul_b = MUL_B_W'(roll_g_ff) - MUL_B_W'(roll_a_ff);
         end
         default: ;
      endcase
   end

   // consume the registered product
   always_comb begin
      prod_low    = prod[35:0];
      prod_rnd    = (prod + PROD_W'(32768)) >>> 16;
      blend_step  = prod_rnd[35:0];
      yaw_in      = sat32(36'(yaw_angle_ff) + prod_low);
      pitch_g_in  = sat32(36'(pitch_angle_ff) + prod_low);
      roll_g_in   = sat32(36'(roll_angle_ff) - prod_low);
      pitch_blend = sat32(36'(pitch_a_ff) + blend_step);
      roll_blend  = sat32(36'(roll_a_ff) + blend_step);
      temp_in     = prod_rnd[15:0] + TEMP_OFFSET;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_IDLE;
         gyro_weight_ff    <= WEIGHT_RESET;
         gyro_step_gain_ff <= GAIN_RESET;
         yaw_angle_ff      <= '0;
         pitch_angle_ff    <= '0;
         roll_angle_ff     <= '0;
         rsp_tvalid_ff     <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_addr)
               REG_GYRO_WEIGHT:    gyro_weight_ff    <= csr_wdata;
               REG_GYRO_STEP_GAIN: gyro_step_gain_ff <= csr_wdata[15:0];
               default: ;
            endcase
         end
         case (state_ff)
            S_GYRO_P:    yaw_angle_ff   <= yaw_in;
            S_BLEND_R:   pitch_angle_ff <= pitch_blend;
            S_BLEND_FIN: roll_angle_ff  <= roll_blend;
            default: ;
         endcase
         if (rsp_load) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_tvalid) begin
         accel_x_ff  <= req_tdata[15:0];
         accel_y_ff  <= req_tdata[31:16];
         accel_z_ff  <= req_tdata[47:32];
         gyro_x_ff   <= req_tdata[63:48];
         gyro_y_ff   <= req_tdata[79:64];
         gyro_z_ff   <= req_tdata[95:80];
         temp_raw_ff <= req_tdata[111:96];
      end
      case (state_ff)
         S_GYRO_R:   pitch_g_ff <= pitch_g_in;
         S_TEMP:     roll_g_ff  <= roll_g_in;
         S_TEMP_FIN: temp_c_ff  <= temp_in;
         S_WAIT_P:   if (cordic_done) pitch_a_ff <= cordic_angle;
         S_WAIT_R:   if (cordic_done) roll_a_ff  <= cordic_angle;
         default: ;
      endcase
      if (rsp_load) begin
         rsp_tdata_ff <= {temp_c_ff, yaw_angle_ff, roll_angle_ff, pitch_angle_ff};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

### rtl/icaf_checker.sv
module icaf_checker
   import icaf_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_W-1:0]      rsp_tdata
);

   // after reset the block is empty and open for a request
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && req_tready))
      else $error("block not empty after reset");

   // one request at a time: the port closes right after an accept
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while another is in work");

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed or dropped");

   // temperature conversion stays inside the range of a 16-bit raw word
   a_temp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[111:96]) >= -16'sd19750 &&
                      $signed(rsp_tdata[111:96]) <= 16'sd30502))
      else $error("temperature out of range");

endmodule

bind imu_complementary_attitude_filter icaf_checker u_icaf_checker (.*);

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import icaf_pkg::*;

   localparam int  TILT_STEPS     = 16;
   localparam int  ROUND_SHIFT    = 8;         // Q.24 accumulator down to Q16.16
   localparam int  SETTLE_CYCLES  = 60;
   localparam int  TIMEOUT_CYCLES = 400000;
   localparam longint RIGHT_ANGLE_Q24 = 64'sd1509949440;
   localparam longint ATAN_DEG_Q24 [TILT_STEPS] = '{
      754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
      15018523, 7509720, 3754917, 1877466, 938734, 469367,
      234684, 117342, 58671, 29335
   };

   typedef struct packed {
      logic signed [15:0] temp;
      logic signed [15:0] gz;
      logic signed [15:0] gy;
      logic signed [15:0] gx;
      logic signed [15:0] az;
      logic signed [15:0] ay;
      logic signed [15:0] ax;
   } imu_sample_t;

   typedef struct packed {
      logic signed [15:0] temp_c;
      logic signed [31:0] yaw;
      logic signed [31:0] roll;
      logic signed [31:0] pitch;
   } attitude_t;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   // accel_x_raw, accel_y_raw, accel_z_raw, gyro_x_raw, gyro_y_raw, gyro_z_raw, temp_raw
   logic [REQ_W-1:0]      req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // pitch_deg, roll_deg, yaw_deg, temp_c
   logic [RSP_W-1:0]      rsp_tdata;
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   attitude_t pending_attitude [$];
   int        mismatch_count = 0;
   int        cycle_count = 0;
   bit        idle_on = 1'b1;

   // filter state as the block should hold it
   int                 blend_weight = 62415;
   int                 step_gain    = 20;
   logic signed [31:0] yaw_now      = '0;
   logic signed [31:0] pitch_now    = '0;
   logic signed [31:0] roll_now     = '0;

   imu_complementary_attitude_filter u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic logic signed [31:0] clamp32(input longint v);
      if (v > 64'sd2147483647) begin
         return 32'sh7FFFFFFF;
      end else if (v < -64'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   // four-quadrant atan2(num, den) in degrees by vectoring rotations
   function automatic logic signed [31:0] tilt_deg(input longint num, input longint den);
      longint x, y, z, t, dx, dy;
      if (num == 0 && den == 0) begin
         return '0;
      end
      x = den * 16384;
      y = num * 16384;
      z = 0;
      // fold the left half-plane into the right one first
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t; z = RIGHT_ANGLE_Q24;
         end else begin
            t = x; x = -y; y = t; z = -RIGHT_ANGLE_Q24;
         end
      end
      for (int i = 0; i < TILT_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y > 0) begin
            x = x + dx; y = y - dy; z = z + ATAN_DEG_Q24[i];
         end else begin
            x = x - dx; y = y + dy; z = z - ATAN_DEG_Q24[i];
         end
      end
      z = (z + (64'sd1 <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
      return clamp32(z);
   endfunction

   function automatic logic signed [31:0] mix(input logic signed [31:0] g,
                                              input logic signed [31:0] a,
                                              input longint w);
      longint s;
      s = w * longint'(g) + (65536 - w) * longint'(a) + 32768;
      return clamp32(s >>> 16);
   endfunction

   function automatic void advance_attitude(input imu_sample_t s, output attitude_t r);
      longint             w, tc;
      logic signed [31:0] pitch_g, roll_g, pitch_a, roll_a;
      w       = (blend_weight > 65536) ? 65536 : blend_weight;
      yaw_now = clamp32(longint'(yaw_now) + longint'(s.gz) * step_gain);
      pitch_g = clamp32(longint'(pitch_now) + longint'(s.gx) * step_gain);
      roll_g  = clamp32(longint'(roll_now) - longint'(s.gy) * step_gain);
      pitch_a = tilt_deg(s.ay, s.az);
      roll_a  = tilt_deg(s.ax, s.az);
      pitch_now = mix(pitch_g, pitch_a, w);
      roll_now  = mix(roll_g, roll_a, w);
      tc = ((longint'(s.temp) * 50251 + 32768) >>> 16) + 5376;
      r.pitch  = pitch_now;
      r.roll   = roll_now;
      r.yaw    = yaw_now;
      r.temp_c = tc[15:0];
   endfunction

   // mostly back-to-back, sometimes a short gap, now and then a long one
   function automatic int pick_gap();
      int r;
      if (!idle_on) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end else if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   function automatic logic signed [15:0] rand_word();
      int r;
      r = $urandom_range(0, 15);
      case (r)
         0: begin
            return 16'sh8000;
         end
         1: begin
            return 16'sh7FFF;
         end
         2: begin
            return '0;
         end
         3, 4: begin
            return 16'($urandom_range(0, 64) - 32);
         end
         default: begin
            return 16'($urandom);
         end
      endcase
   endfunction

   function automatic imu_sample_t rand_sample();
      imu_sample_t s;
      s.ax   = rand_word();
      s.ay   = rand_word();
      s.az   = rand_word();
      s.gx   = rand_word();
      s.gy   = rand_word();
      s.gz   = rand_word();
      s.temp = rand_word();
      if ($urandom_range(0, 19) == 0) begin
         s.ax = '0; s.ay = '0; s.az = '0;
      end
      return s;
   endfunction

   function automatic imu_sample_t sample_of(input int ax, input int ay, input int az,
                                             input int gx, input int gy, input int gz,
                                             input int temp);
      imu_sample_t s;
      s.ax = 16'(ax); s.ay = 16'(ay); s.az = 16'(az);
      s.gx = 16'(gx); s.gy = 16'(gy); s.gz = 16'(gz);
      s.temp = 16'(temp);
      return s;
   endfunction

   task automatic send_sample(input imu_sample_t s);
      int        gap;
      attitude_t predicted;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      do @(posedge clock); while (!req_tready);
      advance_attitude(s, predicted);
      pending_attitude.push_back(predicted);
   endtask

   // hold requests until every result is back
   task automatic wait_until_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (pending_attitude.size() == 0);
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_ADDR_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we    <= 1'b0;
      if (idx == REG_GYRO_WEIGHT) begin
         blend_weight = int'(val);
      end else if (idx == REG_GYRO_STEP_GAIN) begin
         step_gain = int'(val[15:0]);
      end
   endtask

   task automatic test_reset_defaults();
      send_sample(sample_of(0, 0, 0, 0, 0, 0, 0));
      send_sample(sample_of(32767, 32767, 32767, 32767, 32767, 32767, 32767));
      send_sample(sample_of(-32768, -32768, -32768, -32768, -32768, -32768, -32768));
      // z negative: upper and lower half-planes, and y exactly zero
      send_sample(sample_of(-4000, 5000, -8000, 100, -100, 50, 1000));
      send_sample(sample_of(0, 0, -16384, -200, 300, -5, -1000));
      send_sample(sample_of(-7000, -9000, -12000, 7, 9, 11, 333));
      send_sample(sample_of(16384, -16384, 0, 0, 0, 0, -334));
   endtask

   task automatic test_weight_extremes();
      wait_until_drained();
      write_csr(REG_GYRO_WEIGHT, 17'd0);
      send_sample(sample_of(1200, -3000, 16000, 500, 500, 500, 20000));
      send_sample(sample_of(-16000, 8000, -100, -500, 700, -900, -20000));
      wait_until_drained();
      write_csr(REG_GYRO_WEIGHT, WEIGHT_ONE);
      write_csr(REG_GYRO_STEP_GAIN, 17'd0);
      send_sample(sample_of(5000, 5000, 5000, 32767, -32768, 32767, 1));
      wait_until_drained();
      write_csr(REG_GYRO_STEP_GAIN, 17'd300);
      send_sample(sample_of(-5000, 2000, 9000, 1000, -2000, 3000, -1));
      // weights above one must behave as exactly one
      wait_until_drained();
      write_csr(REG_GYRO_WEIGHT, 17'h1FFFF);
      send_sample(sample_of(3000, -12000, 4000, -1000, 2000, -3000, 12345));
      send_sample(sample_of(0, 32767, -32768, 32767, 32767, 32767, -12345));
      wait_until_drained();
      write_csr(REG_GYRO_WEIGHT, 17'd65537);
      send_sample(sample_of(-32768, 0, 1, -1, 1, -1, 0));
   endtask

   task automatic test_angle_saturation();
      wait_until_drained();
      write_csr(REG_GYRO_WEIGHT, WEIGHT_ONE);
      // bit 16 must be dropped by the gain register
      write_csr(REG_GYRO_STEP_GAIN, 17'h1FFFF);
      repeat (3) send_sample(sample_of(100, 100, 100, 32767, -32768, 32767, 0));
      repeat (3) send_sample(sample_of(-100, -100, -100, -32768, 32767, -32768, 0));
      wait_until_drained();
      write_csr(REG_GYRO_WEIGHT, WEIGHT_RESET);
      write_csr(REG_GYRO_STEP_GAIN, 17'(GAIN_RESET));
   endtask

   task automatic test_random_stream();
      int weight_val;
      int gain_val;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               weight_val = WEIGHT_RESET; gain_val = GAIN_RESET;
            end
            1: begin
               weight_val = 0; gain_val = $urandom_range(0, 200);
            end
            2: begin
               weight_val = WEIGHT_ONE; gain_val = 65535;
            end
            3: begin
               weight_val = $urandom_range(65537, 131071); gain_val = $urandom_range(0, 65535);
            end
            4: begin
               weight_val = $urandom_range(0, 65536); gain_val = 0;
            end
            default: begin
               weight_val = $urandom_range(0, 65536); gain_val = $urandom_range(1000, 65535);
            end
         endcase
         wait_until_drained();
         write_csr(REG_GYRO_WEIGHT, 17'(weight_val));
         write_csr(REG_GYRO_STEP_GAIN, 17'(gain_val));
         for (int n = 0; n < 117; n++) begin
            if (n % 40 == 0) begin
               idle_on = (phase != 2) && ($urandom_range(0, 3) != 0);
            end
            if (n == 60) begin
               wait_until_drained();
            end
            send_sample(rand_sample());
         end
      end
      idle_on = 1'b1;
   endtask

   function automatic void check_field(input string name, input longint want,
                                       input longint got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      attitude_t got;
      attitude_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_attitude.size() == 0) begin
            $error("result with no request outstanding: %h", rsp_tdata);
            mismatch_count++;
         end else begin
            want = pending_attitude.pop_front();
            check_field("pitch_deg", want.pitch, got.pitch);
            check_field("roll_deg", want.roll, got.roll);
            check_field("yaw_deg", want.yaw, got.yaw);
            check_field("temp_c", want.temp_c, got.temp_c);
         end
      end
   end

   // receiver: stall in bursts, always back to ready between stalls
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   initial begin
      while (cycle_count < TIMEOUT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Mismatches found");
      $finish;
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_we     = 1'b0;
      csr_addr   = '0;
      csr_wdata  = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_weight_extremes();
      test_angle_saturation();
      test_random_stream();
      wait_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
